### design/witness_path_search_macros.svh
`ifndef WITNESS_PATH_SEARCH_MACROS_SVH
`define WITNESS_PATH_SEARCH_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define WPS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/wps_pkg.sv
package wps_pkg;

   localparam int NODE_BITS  = 8;
   localparam int MAX_NODES  = 256;
   localparam int SLOT_BITS  = 3;
   localparam int MAX_DEGREE = 8;
   localparam int EDGE_AW    = NODE_BITS + SLOT_BITS;
   localparam int SLOT_TOTAL = MAX_NODES * MAX_DEGREE;
   localparam int COST_BITS  = 32;
   localparam int COUNT_BITS = 9;

   localparam logic [COST_BITS-1:0]  INF_COST        = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET     = COUNT_BITS'(256);
   localparam logic [COUNT_BITS-1:0] MAX_NODES_COUNT = COUNT_BITS'(MAX_NODES);

   localparam logic [1:0] OP_EDGE  = 2'd0;
   localparam logic [1:0] OP_FLAG  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] KIND_SKIP    = 2'd0;
   localparam logic [1:0] KIND_ADD     = 2'd1;
   localparam logic [1:0] KIND_REPLACE = 2'd2;

   typedef logic [NODE_BITS-1:0] node_type;
   typedef logic [COST_BITS-1:0] cost_type;

   typedef struct packed {
      cost_type cost;
      node_type node;
   } heap_entry_type;

   typedef struct packed {
      logic     present;
      node_type target;
      cost_type cost;
   } edge_entry_type;

   // Heap order: lower cost first, lower node number breaks a tie.
   function automatic logic entry_less(heap_entry_type a, heap_entry_type b);
      logic result;
      if (a.cost != b.cost) begin
         result = a.cost < b.cost;
      end else begin
         result = a.node < b.node;
      end
      return result;
   endfunction

endpackage

### design/wps_req_if.sv
interface wps_req_if;
   import wps_pkg::*;

   logic           valid;
   logic           ready;
   logic [1:0]     operation;
   node_type       first_node;
   node_type       second_node;
   node_type       banned_node;
   cost_type       distance_cap;
   logic [2:0]     edge_slot;
   cost_type       edge_weight;
   logic           edge_valid;
   logic           node_active;

   modport source (output valid, operation, first_node, second_node, banned_node,
                   distance_cap, edge_slot, edge_weight, edge_valid, node_active,
                   input ready);
   modport sink (input valid, operation, first_node, second_node, banned_node,
                 distance_cap, edge_slot, edge_weight, edge_valid, node_active,
                 output ready);
endinterface

interface wps_rsp_if;
   logic       valid;
   logic       ready;
   logic       shortcut_needed;
   logic [1:0] shortcut_kind;
   logic       bad_node;

   modport source (output valid, shortcut_needed, shortcut_kind, bad_node, input ready);
   modport sink (input valid, shortcut_needed, shortcut_kind, bad_node, output ready);
endinterface

### design/witness_path_search.sv
// Edge and flag writes go to memory as they are accepted; one request is worked at a time.
// A query scans up to the source's 8 slots for a direct edge to the destination, then,
// unless that edge is within the cap or an end node is out of range, runs the search.
// A query with the banned node at either end skips both the scan and the search.
// When the search ends, the result waits in S_DONE until the response channel can take it.
// After reset a pass clears the edge memory and marks all nodes active before requests flow.
module witness_path_search #(
   parameter int HEAP_DEPTH = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   wps_req_if.sink                         req_chan,
   wps_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [wps_pkg::COUNT_BITS-1:0]  csr_write_data
);
   import wps_pkg::*;

   localparam int HEAP_AW = $clog2(HEAP_DEPTH);
   localparam int HSZ_W   = HEAP_AW + 1;
   localparam int HIX_W   = HEAP_AW + 2;
   localparam logic [HSZ_W-1:0] HEAP_FULL = HSZ_W'(HEAP_DEPTH);
   localparam logic [SLOT_BITS:0] SLOT_END = (SLOT_BITS+1)'(MAX_DEGREE);

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_DRD  = 5'd2;
   localparam logic [4:0] S_DCHK = 5'd3;
   localparam logic [4:0] S_INIT = 5'd4;
   localparam logic [4:0] S_P0   = 5'd5;
   localparam logic [4:0] S_P1   = 5'd6;
   localparam logic [4:0] S_P2   = 5'd7;
   localparam logic [4:0] S_SD0  = 5'd8;
   localparam logic [4:0] S_SD1  = 5'd9;
   localparam logic [4:0] S_SD2  = 5'd10;
   localparam logic [4:0] S_SD3  = 5'd11;
   localparam logic [4:0] S_V0   = 5'd12;
   localparam logic [4:0] S_V1   = 5'd13;
   localparam logic [4:0] S_E0   = 5'd14;
   localparam logic [4:0] S_E1   = 5'd15;
   localparam logic [4:0] S_E2   = 5'd16;
   localparam logic [4:0] S_SU0  = 5'd17;
   localparam logic [4:0] S_SU1  = 5'd18;
   localparam logic [4:0] S_DONE = 5'd19;

   // Control registers
   logic [4:0]            state_ff, state_in;
   logic [EDGE_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [COUNT_BITS-1:0] node_count_ff, node_count_in;
   logic [HSZ_W-1:0]      heap_size_ff, heap_size_in;
   logic [MAX_NODES-1:0]  best_vld_ff, best_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   node_type              q_src_ff, q_src_in;
   node_type              q_dst_ff, q_dst_in;
   node_type              q_ban_ff, q_ban_in;
   cost_type              q_cap_ff, q_cap_in;
   logic                  has_direct_ff, has_direct_in;
   logic [SLOT_BITS:0]    slot_ff, slot_in;
   logic [HEAP_AW-1:0]    hidx_ff, hidx_in;
   heap_entry_type        top_ff, top_in;
   heap_entry_type        elem_ff, elem_in;
   heap_entry_type        lchild_ff, lchild_in;
   heap_entry_type        rchild_ff, rchild_in;
   logic                  r_ok_ff, r_ok_in;
   cost_type              nd_ff, nd_in;
   node_type              tgt_ff, tgt_in;
   logic                  res_needed_ff, res_needed_in;
   logic [1:0]            res_kind_ff, res_kind_in;
   logic                  res_bad_ff, res_bad_in;
   logic                  rsp_needed_ff, rsp_needed_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   // Memories
   edge_entry_type        edge_mem [SLOT_TOTAL];
   logic                  live_mem [MAX_NODES];
   cost_type              best_mem [MAX_NODES];
   heap_entry_type        heap_mem [HEAP_DEPTH];

   logic                  edge_we;
   logic [EDGE_AW-1:0]    edge_waddr, edge_raddr;
   edge_entry_type        edge_wdata, edge_rdata_ff;
   logic                  live_we, live_wdata, live_rdata_ff;
   node_type              live_waddr, live_raddr;
   logic                  best_we;
   node_type              best_waddr, best_raddr;
   cost_type              best_wdata, best_rdata_ff;
   logic                  best_rvld_ff;
   logic                  heap_we;
   logic [HEAP_AW-1:0]    heap_waddr, heap_raddr;
   heap_entry_type        heap_wdata, heap_rdata_ff;

   logic [COUNT_BITS-1:0] limit;
   logic                  ends_bad;
   logic                  req_fire;
   logic [HIX_W-1:0]      lidx, ridx;
   logic [HEAP_AW-1:0]    pidx;
   logic [COST_BITS:0]    sum;
   cost_type              best_seen;
   heap_entry_type        dchk_entry;
   edge_entry_type        edge_cur;
   logic                  l_less, r_less;
   heap_entry_type        pick;
   logic                  top_done;

   assign limit    = (node_count_ff > MAX_NODES_COUNT) ? MAX_NODES_COUNT : node_count_ff;
   assign ends_bad = ({1'b0, q_src_ff} >= limit) || ({1'b0, q_dst_ff} >= limit);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign lidx = (HIX_W'(hidx_ff) << 1) + HIX_W'(1);
   assign ridx = lidx + HIX_W'(1);
   assign pidx = (hidx_ff - HEAP_AW'(1)) >> 1;

   assign edge_cur  = edge_rdata_ff;
   assign sum       = {1'b0, top_ff.cost} + {1'b0, edge_cur.cost};
   assign best_seen = best_rvld_ff ? best_rdata_ff : INF_COST;
   assign dchk_entry = heap_rdata_ff;

   // Smallest of the hole entry and its children; the hole wins ties, then the left child.
   assign l_less = entry_less(lchild_ff, elem_ff);
   assign pick   = l_less ? lchild_ff : elem_ff;
   assign r_less = r_ok_ff && entry_less(rchild_ff, pick);
   assign top_done = (top_ff.cost >= q_cap_ff);

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.shortcut_needed = rsp_needed_ff;
   assign rsp_chan.shortcut_kind   = rsp_kind_ff;
   assign rsp_chan.bad_node        = rsp_bad_ff;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      node_count_in = csr_write_enable ? csr_write_data : node_count_ff;
      heap_size_in  = heap_size_ff;
      best_vld_in   = best_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      q_src_in      = q_src_ff;
      q_dst_in      = q_dst_ff;
      q_ban_in      = q_ban_ff;
      q_cap_in      = q_cap_ff;
      has_direct_in = has_direct_ff;
      slot_in       = slot_ff;
      hidx_in       = hidx_ff;
      top_in        = top_ff;
      elem_in       = elem_ff;
      lchild_in     = lchild_ff;
      rchild_in     = rchild_ff;
      r_ok_in       = r_ok_ff;
      nd_in         = nd_ff;
      tgt_in        = tgt_ff;
      res_needed_in = res_needed_ff;
      res_kind_in   = res_kind_ff;
      res_bad_in    = res_bad_ff;
      rsp_needed_in = rsp_needed_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_bad_in    = rsp_bad_ff;

      edge_we    = 1'b0;
      edge_waddr = {req_chan.first_node, req_chan.edge_slot};
      edge_wdata = '{present: req_chan.edge_valid, target: req_chan.second_node,
                     cost: req_chan.edge_weight};
      edge_raddr = {q_src_ff, slot_ff[SLOT_BITS-1:0]};
      live_we    = 1'b0;
      live_waddr = req_chan.first_node;
      live_wdata = req_chan.node_active;
      live_raddr = edge_cur.target;
      best_we    = 1'b0;
      best_waddr = tgt_ff;
      best_wdata = nd_ff;
      best_raddr = edge_cur.target;
      heap_we    = 1'b0;
      heap_waddr = hidx_ff;
      heap_wdata = elem_ff;
      heap_raddr = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLR: begin
            edge_we    = 1'b1;
            edge_waddr = clr_cnt_ff;
            edge_wdata = '0;
            if (clr_cnt_ff[EDGE_AW-1:NODE_BITS] == '0) begin
               live_we    = 1'b1;
               live_waddr = clr_cnt_ff[NODE_BITS-1:0];
               live_wdata = 1'b1;
            end
            clr_cnt_in = clr_cnt_ff + EDGE_AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.operation)
                  OP_EDGE: begin
                     edge_we = 1'b1;
                  end
                  OP_FLAG: begin
                     live_we = 1'b1;
                  end
                  OP_QUERY: begin
                     q_src_in      = req_chan.first_node;
                     q_dst_in      = req_chan.second_node;
                     q_ban_in      = req_chan.banned_node;
                     q_cap_in      = req_chan.distance_cap;
                     has_direct_in = 1'b0;
                     slot_in       = '0;
                     res_needed_in = 1'b0;
                     res_kind_in   = KIND_SKIP;
                     res_bad_in    = 1'b0;
                     if (req_chan.first_node == req_chan.banned_node ||
                         req_chan.second_node == req_chan.banned_node) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_DRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRD: begin
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (edge_cur.present && edge_cur.target == q_dst_ff) begin
               has_direct_in = 1'b1;
               if (edge_cur.cost <= q_cap_ff) begin
                  state_in = S_DONE;
               end else if (ends_bad) begin
                  res_bad_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_INIT;
               end
            end else if (slot_ff == SLOT_END - (SLOT_BITS+1)'(1)) begin
               if (ends_bad) begin
                  res_bad_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_INIT;
               end
            end else begin
               slot_in  = slot_ff + (SLOT_BITS+1)'(1);
               state_in = S_DRD;
            end
         end
         S_INIT: begin
            best_vld_in           = '0;
            best_vld_in[q_src_ff] = 1'b1;
            best_we               = 1'b1;
            best_waddr            = q_src_ff;
            best_wdata            = '0;
            heap_we               = 1'b1;
            heap_waddr            = '0;
            heap_wdata            = '{cost: '0, node: q_src_ff};
            heap_size_in          = HSZ_W'(1);
            state_in              = S_P0;
         end
         S_P0: begin
            if (heap_size_ff == '0) begin
               res_needed_in = 1'b1;
               res_kind_in   = has_direct_ff ? KIND_REPLACE : KIND_ADD;
               state_in      = S_DONE;
            end else begin
               heap_raddr = '0;
               state_in   = S_P1;
            end
         end
         S_P1: begin
            top_in       = dchk_entry;
            heap_size_in = heap_size_ff - HSZ_W'(1);
            heap_raddr   = HEAP_AW'(heap_size_ff - HSZ_W'(1));
            state_in     = S_P2;
         end
         S_P2: begin
            elem_in = heap_rdata_ff;
            hidx_in = '0;
            state_in = (heap_size_ff == '0) ? S_V0 : S_SD0;
         end
         S_SD0: begin
            if (lidx >= HIX_W'(heap_size_ff)) begin
               heap_we  = 1'b1;
               state_in = S_V0;
            end else begin
               heap_raddr = lidx[HEAP_AW-1:0];
               state_in   = S_SD1;
            end
         end
         S_SD1: begin
            lchild_in = heap_rdata_ff;
            if (ridx < HIX_W'(heap_size_ff)) begin
               heap_raddr = ridx[HEAP_AW-1:0];
               r_ok_in    = 1'b1;
               state_in   = S_SD2;
            end else begin
               r_ok_in  = 1'b0;
               state_in = S_SD3;
            end
         end
         S_SD2: begin
            rchild_in = heap_rdata_ff;
            state_in  = S_SD3;
         end
         S_SD3: begin
            heap_we = 1'b1;
            if (r_less) begin
               heap_wdata = rchild_ff;
               hidx_in    = ridx[HEAP_AW-1:0];
               state_in   = S_SD0;
            end else if (l_less) begin
               heap_wdata = lchild_ff;
               hidx_in    = lidx[HEAP_AW-1:0];
               state_in   = S_SD0;
            end else begin
               state_in = S_V0;
            end
         end
         S_V0: begin
            best_raddr = top_ff.node;
            state_in   = S_V1;
         end
         S_V1: begin
            // A stale heap entry is skipped without expanding it.
            if (top_ff.cost != best_seen) begin
               state_in = S_P0;
            end else if (top_ff.node == q_dst_ff) begin
               res_needed_in = top_done;
               res_kind_in   = top_done ? (has_direct_ff ? KIND_REPLACE : KIND_ADD)
                                        : KIND_SKIP;
               state_in      = S_DONE;
            end else if (top_ff.cost > q_cap_ff) begin
               res_needed_in = 1'b1;
               res_kind_in   = has_direct_ff ? KIND_REPLACE : KIND_ADD;
               state_in      = S_DONE;
            end else begin
               slot_in  = '0;
               state_in = S_E0;
            end
         end
         S_E0: begin
            if (slot_ff == SLOT_END) begin
               state_in = S_P0;
            end else begin
               edge_raddr = {top_ff.node, slot_ff[SLOT_BITS-1:0]};
               state_in   = S_E1;
            end
         end
         S_E1: begin
            tgt_in = edge_cur.target;
            nd_in  = sum[COST_BITS] ? INF_COST : sum[COST_BITS-1:0];
            if (edge_cur.present && ({1'b0, edge_cur.target} < limit) &&
                edge_cur.target != q_ban_ff) begin
               state_in = S_E2;
            end else begin
               slot_in  = slot_ff + (SLOT_BITS+1)'(1);
               state_in = S_E0;
            end
         end
         S_E2: begin
            if (live_rdata_ff && nd_ff < best_seen && nd_ff <= q_cap_ff) begin
               best_we             = 1'b1;
               best_vld_in[tgt_ff] = 1'b1;
               if (heap_size_ff >= HEAP_FULL) begin
                  slot_in  = slot_ff + (SLOT_BITS+1)'(1);
                  state_in = S_E0;
               end else begin
                  hidx_in      = heap_size_ff[HEAP_AW-1:0];
                  heap_size_in = heap_size_ff + HSZ_W'(1);
                  elem_in      = '{cost: nd_ff, node: tgt_ff};
                  state_in     = S_SU0;
               end
            end else begin
               slot_in  = slot_ff + (SLOT_BITS+1)'(1);
               state_in = S_E0;
            end
         end
         S_SU0: begin
            if (hidx_ff == '0) begin
               heap_we  = 1'b1;
               slot_in  = slot_ff + (SLOT_BITS+1)'(1);
               state_in = S_E0;
            end else begin
               heap_raddr = pidx;
               state_in   = S_SU1;
            end
         end
         S_SU1: begin
            heap_we = 1'b1;
            if (entry_less(elem_ff, heap_rdata_ff)) begin
               heap_wdata = heap_rdata_ff;
               hidx_in    = pidx;
               state_in   = S_SU0;
            end else begin
               slot_in  = slot_ff + (SLOT_BITS+1)'(1);
               state_in = S_E0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_needed_in = res_needed_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_bad_in    = res_bad_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_cnt_ff    <= '0;
         node_count_ff <= COUNT_RESET;
         heap_size_ff  <= '0;
         best_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         node_count_ff <= node_count_in;
         heap_size_ff  <= heap_size_in;
         best_vld_ff   <= best_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_src_ff      <= q_src_in;
      q_dst_ff      <= q_dst_in;
      q_ban_ff      <= q_ban_in;
      q_cap_ff      <= q_cap_in;
      has_direct_ff <= has_direct_in;
      slot_ff       <= slot_in;
      hidx_ff       <= hidx_in;
      top_ff        <= top_in;
      elem_ff       <= elem_in;
      lchild_ff     <= lchild_in;
      rchild_ff     <= rchild_in;
      r_ok_ff       <= r_ok_in;
      nd_ff         <= nd_in;
      tgt_ff        <= tgt_in;
      res_needed_ff <= res_needed_in;
      res_kind_ff   <= res_kind_in;
      res_bad_ff    <= res_bad_in;
      rsp_needed_ff <= rsp_needed_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      edge_rdata_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
      live_rdata_ff <= live_mem[live_raddr];
   end

   always_ff @(posedge clock) begin
      if (best_we) begin
         best_mem[best_waddr] <= best_wdata;
      end
      best_rdata_ff <= best_mem[best_raddr];
      best_rvld_ff  <= best_vld_ff[best_raddr];
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_waddr] <= heap_wdata;
      end
      heap_rdata_ff <= heap_mem[heap_raddr];
   end

endmodule

### design/wps_checker.sv
`include "witness_path_search_macros.svh"

module wps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_needed,
   input logic [1:0] rsp_kind,
   input logic       rsp_bad
);
   import wps_pkg::*;

   // A pending response must not be withdrawn.
   `WPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `WPS_ASSERT_SAME(a_kind_match, rsp_valid, rsp_needed == (rsp_kind != KIND_SKIP), "kind disagrees with needed flag")

   `WPS_ASSERT_SAME(a_bad_skip, rsp_valid && rsp_bad, !rsp_needed && rsp_kind == KIND_SKIP, "bad node with a shortcut")

   // Writes never produce a response.
   `WPS_ASSERT_NEXT(a_write_quiet, req_valid && req_ready && req_operation != OP_QUERY && !rsp_valid, !rsp_valid, "response after a write")

endmodule

bind witness_path_search wps_checker u_wps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_needed    (rsp_chan.shortcut_needed),
   .rsp_kind      (rsp_chan.shortcut_kind),
   .rsp_bad       (rsp_chan.bad_node)
);
